>>> sv/irt_pkg.sv
// Shared types and codes for the interval reservation table.
// No dependencies; every other file of the block refers to it by scoped names.

package irt_pkg;

   localparam int TAG_W    = 16;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;

   // Request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   // One booked interval as held in the table memory
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] length;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_PLACE,
      ST_RESP
   } state_type;

endpackage

>>> sv/irt_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on irt_pkg for field widths.

interface irt_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [irt_pkg::TAG_W-1:0]   interval_tag;
   logic [irt_pkg::TIME_W-1:0]  start_time;
   logic [irt_pkg::TIME_W-1:0]  length_time;

   modport source (output valid, req_type, interval_tag, start_time, length_time,
                   input ready);
   modport sink   (input valid, req_type, interval_tag, start_time, length_time,
                   output ready);
endinterface

interface irt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [irt_pkg::STATUS_W-1:0]  status_code;
   logic [irt_pkg::SLOT_W-1:0]    slot_index;
   logic [irt_pkg::COUNT_W-1:0]   entry_count;

   modport source (output valid, accepted, status_code, slot_index, entry_count,
                   input ready);
   modport sink   (input valid, accepted, status_code, slot_index, entry_count,
                   output ready);
endinterface

>>> sv/interval_reservation_table.sv
// Interval reservation table: top level with the entry memory and its sequencer.
// Depends on irt_pkg and the channel interfaces in irt_if.sv.
//
// Holds up to TABLE_DEPTH non-overlapping intervals sorted by start in one
// synchronous memory (one read, one write per cycle, registered read).
// An insert scans entries from slot 0, reading then comparing each entry,
// until it finds the gap where it fits, then moves the later entries up one
// slot, each with a read and a write, and writes the new entry. Clear,
// table-full and empty-table requests skip the scan. One request is worked
// on at a time; a finished result sits in an output register so the next
// request can be taken meanwhile.
// Entry count wraps to five bits and slot index to four bits on the outputs.

module interval_reservation_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   irt_req_if.sink    req,
   irt_rsp_if.source  rsp
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = irt_pkg::TIME_W + 1;

   // Entry memory
   irt_pkg::entry_type entry_mem [TABLE_DEPTH];

   irt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      mv_ff, mv_in;
   logic [EW-1:0]      prev_end_ff, prev_end_in;
   logic [irt_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic [irt_pkg::TIME_W-1:0] start_ff, start_in;
   logic [irt_pkg::TIME_W-1:0] len_ff, len_in;
   logic [EW-1:0]      new_end_ff, new_end_in;
   logic               res_acc_ff, res_acc_in;
   logic [irt_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [AW-1:0]      res_slot_ff, res_slot_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_acc_ff, out_acc_in;
   logic [irt_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [irt_pkg::SLOT_W-1:0]   out_slot_ff, out_slot_in;
   logic [irt_pkg::COUNT_W-1:0]  out_count_ff, out_count_in;

   irt_pkg::entry_type rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   irt_pkg::entry_type wr_data;

   logic               out_free;
   logic [EW-1:0]      ent_end;
   logic               fits;
   logic [AW+3:0]      slot_wide;
   logic [CW+4:0]      count_wide;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign ent_end  = {1'b0, rd_data_ff.start} + {1'b0, rd_data_ff.length};
   // Fits before this entry: new end below its start, and past the previous end
   assign fits = ((idx_ff == '0) || ({1'b0, start_ff} >= prev_end_ff))
                 && (new_end_ff < {1'b0, rd_data_ff.start});
   assign slot_wide  = {4'b0, res_slot_ff};
   assign count_wide = {5'b0, used_ff};

   assign req.ready       = (state_ff == irt_pkg::ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.accepted    = out_acc_ff;
   assign rsp.status_code = out_status_ff;
   assign rsp.slot_index  = out_slot_ff;
   assign rsp.entry_count = out_count_ff;

   // Sequence scan, move and placement
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      mv_in         = mv_ff;
      prev_end_in   = prev_end_ff;
      tag_in        = tag_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      new_end_in    = new_end_ff;
      res_acc_in    = res_acc_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_acc_in    = out_acc_ff;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_count_in  = out_count_ff;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = '{tag: tag_ff, start: start_ff, length: len_ff};

      // Drop the result once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         irt_pkg::ST_IDLE: begin
            if (req.valid) begin
               tag_in        = req.interval_tag;
               start_in      = req.start_time;
               len_in        = req.length_time;
               new_end_in    = {1'b0, req.start_time} + {1'b0, req.length_time};
               idx_in        = '0;
               pos_in        = '0;
               res_acc_in    = 1'b0;
               res_status_in = irt_pkg::STATUS_OK;
               res_slot_in   = '0;
               if (req.req_type == irt_pkg::REQ_CLEAR) begin
                  used_in    = '0;
                  res_acc_in = 1'b1;
                  state_in   = irt_pkg::ST_RESP;
               end else if (used_ff == CW'(TABLE_DEPTH)) begin
                  res_status_in = irt_pkg::STATUS_FULL;
                  state_in      = irt_pkg::ST_RESP;
               end else if (used_ff == '0) begin
                  state_in = irt_pkg::ST_PLACE;
               end else begin
                  state_in = irt_pkg::ST_READ;
               end
            end
         end
         irt_pkg::ST_READ: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = irt_pkg::ST_CHECK;
         end
         irt_pkg::ST_CHECK: begin
            if (fits) begin
               // Open a hole at this slot by moving later entries up
               pos_in   = idx_ff[AW-1:0];
               mv_in    = used_ff[AW-1:0];
               state_in = irt_pkg::ST_MOVE_RD;
            end else if (CW'(idx_ff + 1'b1) == used_ff) begin
               // Last entry: only the tail is left
               if ({1'b0, start_ff} >= ent_end) begin
                  pos_in   = used_ff[AW-1:0];
                  state_in = irt_pkg::ST_PLACE;
               end else begin
                  res_status_in = irt_pkg::STATUS_OVERLAP;
                  state_in      = irt_pkg::ST_RESP;
               end
            end else begin
               prev_end_in = ent_end;
               idx_in      = CW'(idx_ff + 1'b1);
               state_in    = irt_pkg::ST_READ;
            end
         end
         irt_pkg::ST_MOVE_RD: begin
            rd_addr  = AW'(mv_ff - 1'b1);
            state_in = irt_pkg::ST_MOVE_WR;
         end
         irt_pkg::ST_MOVE_WR: begin
            wr_en   = 1'b1;
            wr_addr = mv_ff;
            wr_data = rd_data_ff;
            mv_in   = AW'(mv_ff - 1'b1);
            if (AW'(mv_ff - 1'b1) == pos_ff) begin
               state_in = irt_pkg::ST_PLACE;
            end else begin
               state_in = irt_pkg::ST_MOVE_RD;
            end
         end
         irt_pkg::ST_PLACE: begin
            wr_en       = 1'b1;
            wr_addr     = pos_ff;
            used_in     = CW'(used_ff + 1'b1);
            res_acc_in  = 1'b1;
            res_slot_in = pos_ff;
            state_in    = irt_pkg::ST_RESP;
         end
         irt_pkg::ST_RESP: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_acc_in    = res_acc_ff;
               out_status_in = res_status_ff;
               out_slot_in   = slot_wide[3:0];
               out_count_in  = count_wide[4:0];
               state_in      = irt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = irt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irt_pkg::ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      mv_ff         <= mv_in;
      prev_end_ff   <= prev_end_in;
      tag_ff        <= tag_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      new_end_ff    <= new_end_in;
      res_acc_ff    <= res_acc_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      out_acc_ff    <= out_acc_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_count_ff  <= out_count_in;
   end

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for interval_reservation_table: directed rows, then random bookings.
// Depends on irt_pkg, the channel interfaces in irt_if.sv and the block's top level.
`timescale 1ns / 100ps

module tb_top;

   localparam int TAG_W    = irt_pkg::TAG_W;
   localparam int TIME_W   = irt_pkg::TIME_W;
   localparam int STATUS_W = irt_pkg::STATUS_W;
   localparam int SLOT_W   = irt_pkg::SLOT_W;
   localparam int COUNT_W  = irt_pkg::COUNT_W;

   localparam logic REQ_INSERT = irt_pkg::REQ_INSERT;
   localparam logic REQ_CLEAR  = irt_pkg::REQ_CLEAR;

   localparam logic [STATUS_W-1:0] STATUS_OK      = irt_pkg::STATUS_OK;
   localparam logic [STATUS_W-1:0] STATUS_OVERLAP = irt_pkg::STATUS_OVERLAP;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = irt_pkg::STATUS_FULL;

   localparam int unsigned DEPTH        = 16;
   localparam int unsigned RANDOM_ITEMS = 1400;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned DIRECTED_N   = 25;

   typedef struct packed {
      logic              req_type;
      logic [TAG_W-1:0]  interval_tag;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] length_time;
   } booking_req_type;

   typedef struct packed {
      logic                accepted;
      logic [STATUS_W-1:0] status_code;
      logic [SLOT_W-1:0]   slot_index;
      logic [COUNT_W-1:0]  entry_count;
   } booking_rsp_type;

   typedef struct packed {
      booking_req_type item;
      logic            typed;
      booking_rsp_type want;
   } stim_row_type;

   typedef enum int unsigned {
      PACE_FREE,
      PACE_MOSTLY,
      PACE_SLOW,
      PACE_PERIODIC
   } rsp_pace_type;

   localparam booking_rsp_type NO_RESULT = '0;

   logic clock = 1'b0;
   logic reset;

   irt_req_if req_ch ();
   irt_rsp_if rsp_ch ();

   interval_reservation_table #(
      .TABLE_DEPTH (DEPTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Shadow copy of the booking table
   logic [TIME_W-1:0] booked_start  [DEPTH];
   logic [TIME_W-1:0] booked_length [DEPTH];
   logic [TAG_W-1:0]  booked_tag    [DEPTH];
   int unsigned       booked_count = 0;

   booking_rsp_type   pending_results [$];
   int unsigned       fail_count = 0;
   int unsigned       burst_left = 0;
   int unsigned       rsp_phase_left = 0;
   rsp_pace_type      rsp_pace = PACE_FREE;

   always #1 clock = ~clock;

   // End of a booked interval, exact in 33 bits
   function automatic logic [TIME_W:0] interval_end(int unsigned idx);
      return {1'b0, booked_start[idx]} + {1'b0, booked_length[idx]};
   endfunction

   // Place or reject one request against the shadow table
   function automatic booking_rsp_type book_request(booking_req_type r);
      booking_rsp_type res;
      logic [TIME_W:0] new_end;
      logic [TIME_W:0] new_start;
      int unsigned     pos;
      int unsigned     i;
      bit              fits;
      res       = '0;
      new_start = {1'b0, r.start_time};
      new_end   = new_start + {1'b0, r.length_time};
      fits      = 1'b0;
      pos       = 0;
      if (r.req_type == REQ_CLEAR) begin
         booked_count = 0;
         res.accepted = 1'b1;
      end else if (booked_count >= DEPTH) begin
         res.status_code = STATUS_FULL;
      end else begin
         // empty table or strictly ahead of the first entry
         if (booked_count == 0 || new_end < {1'b0, booked_start[0]}) fits = 1'b1;
         // first gap between neighbors that holds the interval
         for (i = 0; i + 1 < booked_count && !fits; i++) begin
            if (new_start >= interval_end(i) && new_end < {1'b0, booked_start[i+1]}) begin
               fits = 1'b1;
               pos  = i + 1;
            end
         end
         // tail
         if (!fits && new_start >= interval_end(booked_count - 1)) begin
            fits = 1'b1;
            pos  = booked_count;
         end
         if (!fits) begin
            res.status_code = STATUS_OVERLAP;
         end else begin
            for (i = booked_count; i > pos; i--) begin
               booked_start[i]  = booked_start[i-1];
               booked_length[i] = booked_length[i-1];
               booked_tag[i]    = booked_tag[i-1];
            end
            booked_start[pos]  = r.start_time;
            booked_length[pos] = r.length_time;
            booked_tag[pos]    = r.interval_tag;
            booked_count++;
            res.accepted   = 1'b1;
            res.slot_index = SLOT_W'(pos);
         end
      end
      res.entry_count = COUNT_W'(booked_count);
      return res;
   endfunction

   // Draw one random request: mostly bookings aimed at a free gap, some noise
   function automatic booking_req_type draw_request();
      booking_req_type r;
      int unsigned     pick;
      int unsigned     g;
      int unsigned     idx;
      logic [TIME_W:0] lo;
      logic [TIME_W:0] limit;
      logic [63:0]     span;
      logic [63:0]     off;
      logic [63:0]     room;
      r.req_type     = REQ_INSERT;
      r.interval_tag = TAG_W'($urandom);
      r.start_time   = $urandom;
      r.length_time  = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         r.req_type = REQ_CLEAR;
         return r;
      end
      if (pick < 15) return r;
      // land on or just after an existing start
      if (pick < 25) begin
         if (booked_count != 0) begin
            idx           = $urandom_range(0, booked_count - 1);
            r.start_time  = booked_start[idx] + $urandom_range(0, 3);
            r.length_time = $urandom_range(0, 1000);
         end
         return r;
      end
      // aim at a gap: before the first, between two, or after the last entry
      g     = $urandom_range(0, booked_count);
      lo    = (g == 0) ? '0 : interval_end(g - 1);
      limit = (g == booked_count) ? 33'h1_0000_0000 : {1'b0, booked_start[g]};
      if (lo >= limit) return r;
      span = 64'(limit - lo);
      off  = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 255)) : {$urandom, $urandom};
      off  = off % span;
      r.start_time = TIME_W'(64'(lo) + off);
      pick = $urandom_range(0, 19);
      if (g == booked_count) begin
         if (pick < 2) r.length_time = $urandom;
         else if (pick < 4) r.length_time = '0;
         else r.length_time = $urandom_range(0, 4095);
      end else begin
         room = 64'(limit) - 64'd1 - 64'(r.start_time);
         if (pick == 0) r.length_time = TIME_W'(room + 64'd1);
         else if (pick < 3) r.length_time = TIME_W'(room);
         else if (pick < 11) r.length_time = TIME_W'(64'($urandom_range(0, 63)) > room ?
                                                     room : 64'($urandom_range(0, 63)));
         else r.length_time = TIME_W'(64'($urandom) % (room + 64'd1));
      end
      return r;
   endfunction

   // Drive one item, hold it until taken, then record what it should produce
   task automatic send_request(input booking_req_type r, input bit typed,
                               input booking_rsp_type want);
      booking_rsp_type predicted;
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= r.req_type;
      req_ch.interval_tag <= r.interval_tag;
      req_ch.start_time   <= r.start_time;
      req_ch.length_time  <= r.length_time;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = book_request(r);
      pending_results = {pending_results, (typed ? want : predicted)};
   endtask

   // Insert a gap between bursts of items
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            burst_left = 64;
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (gap != 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Hold off until every outstanding result has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic note_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Stall the result side in phases of different character
   always @(negedge clock) begin
      if (rsp_phase_left == 0) begin
         rsp_pace       = rsp_pace_type'($urandom_range(0, 3));
         rsp_phase_left = $urandom_range(16, 200);
      end else begin
         rsp_phase_left--;
      end
      case (rsp_pace)
         PACE_FREE:   rsp_ch.ready <= 1'b1;
         PACE_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         PACE_SLOW:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ch.ready <= (rsp_phase_left % 8 < 3);
      endcase
   end

   // Compare each result taken with the oldest outstanding one
   always @(posedge clock) begin : check_result
      booking_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %b/%0d/%0d/%0d", $time,
                     rsp_ch.accepted, rsp_ch.status_code, rsp_ch.slot_index,
                     rsp_ch.entry_count);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            note_field("accepted", 32'(want.accepted), 32'(rsp_ch.accepted));
            note_field("status_code", 32'(want.status_code), 32'(rsp_ch.status_code));
            note_field("slot_index", 32'(want.slot_index), 32'(rsp_ch.slot_index));
            note_field("entry_count", 32'(want.entry_count), 32'(rsp_ch.entry_count));
         end
      end
   end

   // Abort when neither channel moves for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      do begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end while (quiet_cycles < QUIET_LIMIT);
      $display("FAIL interval_reservation_table");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed_rows [DIRECTED_N];
      int unsigned  n;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_INSERT;
      req_ch.interval_tag = '0;
      req_ch.start_time   = '0;
      req_ch.length_time  = '0;
      rsp_ch.ready        = 1'b0;

      directed_rows = '{
         // empty table, zero-length tail, ahead of first, overlap
         '{'{REQ_INSERT, 16'h0001, 32'd100, 32'd50}, 1'b1, '{1'b1, STATUS_OK, 4'd0, 5'd1}},
         '{'{REQ_INSERT, 16'h0002, 32'd200, 32'd0}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0003, 32'd10, 32'd89}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0004, 32'd90, 32'd20}, 1'b1, '{1'b0, STATUS_OVERLAP, 4'd0, 5'd3}},
         // exact fit into a gap, then one ending on the next start
         '{'{REQ_INSERT, 16'h0005, 32'd150, 32'd49}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0006, 32'd199, 32'd1}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0007, 32'd0, 32'd0}, 1'b0, NO_RESULT},
         // widest interval at the tail, end past 32 bits
         '{'{REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0008, 32'hFFFF_FFFF, 32'd0}, 1'b1,
           '{1'b0, STATUS_OVERLAP, 4'd0, 5'd6}},
         // fill the gap ahead of the last entry up to a full table
         '{'{REQ_INSERT, 16'h0010, 32'd300, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0011, 32'd400, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0012, 32'd500, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0013, 32'd600, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0014, 32'd700, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0015, 32'd800, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0016, 32'd900, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0017, 32'd1000, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0018, 32'd1100, 32'd10}, 1'b0, NO_RESULT},
         '{'{REQ_INSERT, 16'h0019, 32'd1200, 32'd10}, 1'b0, NO_RESULT},
         // full table, clears, then the widest interval into an empty table
         '{'{REQ_INSERT, 16'hFFFF, 32'd0, 32'hFFFF_FFFF}, 1'b1,
           '{1'b0, STATUS_FULL, 4'd0, 5'd16}},
         '{'{REQ_CLEAR, 16'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
           '{1'b1, STATUS_OK, 4'd0, 5'd0}},
         '{'{REQ_CLEAR, 16'h0000, 32'd0, 32'd0}, 1'b1, '{1'b1, STATUS_OK, 4'd0, 5'd0}},
         '{'{REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
           '{1'b1, STATUS_OK, 4'd0, 5'd1}},
         '{'{REQ_INSERT, 16'h0000, 32'd0, 32'hFFFF_FFFF}, 1'b1,
           '{1'b0, STATUS_OVERLAP, 4'd0, 5'd1}},
         '{'{REQ_CLEAR, 16'hA5A5, 32'd0, 32'd0}, 1'b1, '{1'b1, STATUS_OK, 4'd0, 5'd0}}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (n = 0; n < DIRECTED_N; n++) begin
         pace_sender();
         send_request(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
      end
      wait_for_drain();

      // random bookings, with one full drain halfway
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         pace_sender();
         send_request(draw_request(), 1'b0, NO_RESULT);
      end

      wait_for_drain();
      repeat (64) @(negedge clock);
      if (fail_count == 0)
         $display("PASS interval_reservation_table");
      else
         $display("FAIL interval_reservation_table");
      $finish;
   end

endmodule
